[rtl/checked_small_integer_alu_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the checked small-integer ALU
// Concurrent assertions clocked on clk_i and silenced while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHECKED_SMALL_INTEGER_ALU_MACROS_SVH
`define CHECKED_SMALL_INTEGER_ALU_MACROS_SVH

`ifndef SYNTHESIS
// Hold prop at every clock edge out of reset.
`define CSIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("csia assertion failed");
// When ante holds, cons must hold in the next cycle.
`define CSIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csia assertion failed");
`else
`define CSIA_ASSERT(lbl, prop)
`define CSIA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/csia_pkg.sv]
// ----------------------------------------------------------------------------
// csia_pkg
// Opcodes, range constants and the divider step for the small-integer ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csia_pkg;

  localparam int FieldW        = 31;
  localparam int MagnitudeBits = 30;
  localparam int RangeBits     = (MagnitudeBits < 30) ? MagnitudeBits : 30;
  localparam int DivSteps      = FieldW;
  localparam int ShAmtW        = $clog2(MagnitudeBits);

  localparam logic signed [31:0] SMax   = 32'sd2 ** RangeBits - 32'sd1;
  localparam logic signed [31:0] SMin   = -SMax - 32'sd1;
  localparam logic signed [31:0] MagLim = 32'(MagnitudeBits);

  typedef enum logic [3:0] {
    OpEq    = 4'd0,
    OpLt    = 4'd1,
    OpAdd   = 4'd2,
    OpMul   = 4'd3,
    OpDiv   = 4'd4,
    OpMod   = 4'd5,
    OpAnd   = 4'd6,
    OpOr    = 4'd7,
    OpXor   = 4'd8,
    OpShift = 4'd9
  } kind_e;

  // One item as it moves down the divider pipeline.
  typedef struct packed {
    logic [3:0]        kind;
    logic [FieldW-1:0] val;
    logic              err;
    logic              negq;
    logic [31:0]       rem;
    logic [FieldW-1:0] quo;
    logic [FieldW-1:0] dvs;
  } dstg_t;

  // One restoring division step: shift in the next dividend bit, trial subtract.
  function automatic dstg_t div_step(dstg_t s);
    dstg_t       o;
    logic [31:0] rsh;
    logic [32:0] diff;
    o    = s;
    rsh  = {s.rem[30:0], s.quo[FieldW-1]};
    diff = {1'b0, rsh} - {2'b00, s.dvs};
    o.quo = {s.quo[FieldW-2:0], ~diff[32]};
    o.rem = diff[32] ? rsh : diff[31:0];
    return o;
  endfunction

endpackage

[rtl/checked_small_integer_alu.sv]
// ----------------------------------------------------------------------------
// checked_small_integer_alu
// Overflow-checked ALU for tagged small integers, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                             | tuser
//  s_axis   | in  | [30:0] operand_a, [61:31] operand_b | [3:0] kind
//  m_axis   | out | [30:0] value                      | [0] status
//
//  The pipe is the input register, the decode stage, the 31-step restoring
//  divider with one quotient bit a stage, and the output register.
//  One beat is taken every cycle while the output side keeps up.
//  Every stage advances together: when the output register holds an untaken
//  beat, the whole pipe holds and s_axis_tready_o drops.
//  Reset clears the valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "checked_small_integer_alu_macros.svh"

module checked_small_integer_alu
  import csia_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // operand_a, operand_b, zero pad
  input  logic [3:0]  s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // value, zero pad
  output logic        m_axis_tuser_o    // status
);

  logic adv;

  // Input register
  logic              vld0_q;
  logic [3:0]        kind0_q;
  logic [FieldW-1:0] a0_q, b0_q;

  // Decode stage registers
  logic                    vld1_q;
  dstg_t                   st1_q;
  logic signed [2*FieldW-1:0] prod1_q;

  // Divider chain
  logic [DivSteps-1:0] dvld_q;
  dstg_t               dstg_q [DivSteps];
  dstg_t               st1_m;

  // Output register
  logic              ovld_q;
  logic [3:0]        okind_q;
  logic [FieldW-1:0] oval_q;
  logic              oerr_q;

  assign adv             = !ovld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // --- stage 0: capture the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (adv) begin
      vld0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind0_q <= s_axis_tuser_i;
      a0_q    <= s_axis_tdata_i[FieldW-1:0];
      b0_q    <= s_axis_tdata_i[2*FieldW-1:FieldW];
    end
  end

  // --- stage 1: cheap ops, operand checks, multiply, divider set-up
  logic signed [31:0] a, b, sum, lim, v1;
  logic               rng_ok, e1, negq;
  logic [FieldW-1:0]  absa, absb;
  logic [ShAmtW-1:0]  amt;
  logic signed [31:0] negb;

  always_comb begin
    a      = 32'(signed'(a0_q));
    b      = 32'(signed'(b0_q));
    rng_ok = (a >= SMin) && (a <= SMax) && (b >= SMin) && (b <= SMax);
    sum    = a + b;
    negb   = -b;
    absa   = a[31] ? FieldW'(-a) : a[FieldW-1:0];
    absb   = b[31] ? FieldW'(-b) : b[FieldW-1:0];
    negq   = a[31] ^ b[31];
    lim    = '0;
    amt    = '0;
    v1     = '0;
    e1     = 1'b0;
    case (kind_e'(kind0_q))
      OpEq:  v1 = {31'd0, a == b};
      OpLt:  v1 = {31'd0, a < b};
      OpAdd: begin
        v1 = sum;
        e1 = (sum < SMin) || (sum > SMax);
      end
      OpMul: e1 = 1'b0;
      OpDiv: e1 = (b == '0);
      OpMod: e1 = a[31] || b[31] || (b == '0);
      OpAnd: begin
        v1 = a & b;
        e1 = a[31] || b[31];
      end
      OpOr: begin
        v1 = a | b;
        e1 = a[31] || b[31];
      end
      OpXor: begin
        v1 = a ^ b;
        e1 = a[31] || b[31];
      end
      OpShift: begin
        if (a[31] || (b <= -MagLim) || (b >= MagLim)) begin
          e1 = 1'b1;
        end else if (b > 0) begin
          amt = b[ShAmtW-1:0];
          lim = SMax >>> amt;
          e1  = a > lim;
          v1  = a << amt;
        end else begin
          amt = negb[ShAmtW-1:0];
          v1  = a >>> amt;
        end
      end
      default: e1 = 1'b1;
    endcase
    if (!rng_ok) e1 = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (adv) begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st1_q.kind <= kind0_q;
      st1_q.val  <= v1[FieldW-1:0];
      st1_q.err  <= e1;
      st1_q.negq <= negq;
      st1_q.rem  <= '0;
      st1_q.quo  <= absa;
      st1_q.dvs  <= absb;
      prod1_q    <= (2*FieldW)'(signed'(a0_q)) * (2*FieldW)'(signed'(b0_q));
    end
  end

  // --- merge the product range check ahead of the first divider step
  always_comb begin
    st1_m = st1_q;
    if (kind_e'(st1_q.kind) == OpMul) begin
      st1_m.val = prod1_q[FieldW-1:0];
      if ((prod1_q < (2*FieldW)'(SMin)) || (prod1_q > (2*FieldW)'(SMax))) begin
        st1_m.err = 1'b1;
      end
    end
  end

  // --- divider stages: one quotient bit per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else if (adv) begin
      dvld_q <= {dvld_q[DivSteps-2:0], vld1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dstg_q[0] <= div_step(st1_m);
      for (int i = 1; i < DivSteps; i++) begin
        dstg_q[i] <= div_step(dstg_q[i-1]);
      end
    end
  end

  // --- final stage: sign the quotient, pick the result, zero on error
  dstg_t              fin;
  logic signed [31:0] qs;
  logic [FieldW-1:0]  fval;
  logic               ferr;

  always_comb begin
    fin  = dstg_q[DivSteps-1];
    qs   = fin.negq ? -signed'({1'b0, fin.quo}) : signed'({1'b0, fin.quo});
    fval = fin.val;
    ferr = fin.err;
    case (kind_e'(fin.kind))
      OpDiv: begin
        fval = qs[FieldW-1:0];
        if ((qs < SMin) || (qs > SMax)) ferr = 1'b1;
      end
      OpMod:   fval = fin.rem[FieldW-1:0];
      default: fval = fin.val;
    endcase
    if (ferr) fval = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (adv) begin
      ovld_q <= dvld_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      okind_q <= fin.kind;
      oval_q  <= fval;
      oerr_q  <= ferr;
    end
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {1'b0, oval_q};
  assign m_axis_tuser_o  = oerr_q;

  // --- assertions
  `CSIA_ASSERT(a_err_zero, !(ovld_q && oerr_q) || (oval_q == '0))
  `CSIA_ASSERT(a_cmp_bool,
    !(ovld_q && ((kind_e'(okind_q) == OpEq) || (kind_e'(okind_q) == OpLt)))
    || (oval_q[FieldW-1:1] == '0))
  `CSIA_ASSERT_NEXT(a_div_zero,
    adv && dvld_q[DivSteps-1] && (fin.dvs == '0)
    && ((kind_e'(fin.kind) == OpDiv) || (kind_e'(fin.kind) == OpMod)),
    oerr_q)

endmodule

[tb/sv/checked_small_integer_alu_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_small_integer_alu_test
// Drives opcode and operand beats into the small-integer ALU, predicts each
// value and status with an independent model, and compares the result beats
// in order. A directed table comes first, then random beats.
// ----------------------------------------------------------------------------

module checked_small_integer_alu_test;
  import csia_pkg::*;

  localparam int CyclesLimit = 20000;
  localparam int PipeDepth   = 40;
  localparam int DirN        = 25;
  localparam int RandItems   = 1650;

  typedef struct {
    logic [3:0]        kind;
    logic [FieldW-1:0] a;
    logic [FieldW-1:0] b;
    logic              known;
    logic [FieldW-1:0] val;
    logic              err;
  } stim_row_t;

  typedef struct packed {
    logic [FieldW-1:0] val;
    logic              err;
  } alu_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // operand_a, operand_b, zero pad
  logic [3:0]  s_axis_tuser_i;   // kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // value, zero pad
  logic        m_axis_tuser_o;   // status

  alu_res_t  awaited_results[$];
  stim_row_t dir_rows[DirN];
  int        fail_count;
  int        quiet_cycles;
  int        sent_count;
  int        taken_count;
  bit        no_idle;      // long stretch with neither side idling
  bit        hold_sink;    // receiver holds off to fill the pipe
  bit        stim_done;

  checked_small_integer_alu uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Predict one result from opcode and operands at full 64-bit precision.
  function automatic alu_res_t predict_alu(logic [3:0] kind, logic [FieldW-1:0] ra,
                                           logic [FieldW-1:0] rb);
    longint a, b, r, smax, smin;
    alu_res_t res;
    bit ok;
    a    = longint'(signed'(ra));
    b    = longint'(signed'(rb));
    smax = longint'(SMax);
    smin = longint'(SMin);
    ok   = 1'b1;
    r    = 0;
    if (a < smin || a > smax || b < smin || b > smax) ok = 1'b0;
    else begin
      case (kind)
        OpEq:  r = (a == b);
        OpLt:  r = (a < b);
        OpAdd: r = a + b;
        OpMul: r = a * b;
        OpDiv: begin
          if (b == 0 || (a == smin && b == -1)) ok = 1'b0;
          else r = a / b;
        end
        OpMod: begin
          if (a < 0 || b <= 0) ok = 1'b0;
          else r = a % b;
        end
        OpAnd, OpOr, OpXor: begin
          if (a < 0 || b < 0) ok = 1'b0;
          else if (kind == OpAnd) r = a & b;
          else if (kind == OpOr) r = a | b;
          else r = a ^ b;
        end
        OpShift: begin
          if (a < 0 || b <= -MagnitudeBits || b >= MagnitudeBits) ok = 1'b0;
          else if (a == 0) r = 0;
          else if (b > 0) begin
            if (a > (smax >>> b)) ok = 1'b0;
            else r = a << b;
          end else r = a >>> (-b);
        end
        default: ok = 1'b0;
      endcase
      if (ok && (r < smin || r > smax)) ok = 1'b0;
    end
    res.val = ok ? r[FieldW-1:0] : '0;
    res.err = !ok;
    return res;
  endfunction

  function automatic stim_row_t mk_row(logic [3:0] k, longint a, longint b, bit known = 0,
                                       longint v = 0, bit e = 0);
    stim_row_t s;
    s.kind = k; s.a = a[FieldW-1:0]; s.b = b[FieldW-1:0];
    s.known = known; s.val = v[FieldW-1:0]; s.err = e;
    return s;
  endfunction

  // Random operand: extremes, small values and the full field, both signs.
  function automatic logic [FieldW-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return SMax[FieldW-1:0];
      1: return SMin[FieldW-1:0];
      2: return FieldW'(signed'($urandom_range(0, 80)) - 40);
      3: return FieldW'($urandom_range(0, 1 << 16));
      default: return FieldW'($urandom);
    endcase
  endfunction

  // Offer one beat and hold it until taken.
  task automatic send_op(logic [3:0] kind, logic [FieldW-1:0] a, logic [FieldW-1:0] b);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, b, a};
    s_axis_tuser_i  <= kind;
    awaited_results.push_back(predict_alu(kind, a, b));
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_count++;
    if (!no_idle && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  initial begin
    dir_rows[0]  = mk_row(OpEq, 5, 5, 1, 1, 0);
    dir_rows[1]  = mk_row(OpLt, longint'(SMin), longint'(SMax), 1, 1, 0);
    dir_rows[2]  = mk_row(OpAdd, longint'(SMax), 1, 1, 0, 1);
    dir_rows[3]  = mk_row(OpAdd, longint'(SMin), -1, 1, 0, 1);
    dir_rows[4]  = mk_row(OpAdd, longint'(SMax), longint'(SMin), 1, -1, 0);
    dir_rows[5]  = mk_row(OpMul, longint'(SMin), -1, 1, 0, 1);
    dir_rows[6]  = mk_row(OpMul, 32768, 32768, 1, 0, 1);
    dir_rows[7]  = mk_row(OpMul, -7, 9);
    dir_rows[8]  = mk_row(OpDiv, 100, 0, 1, 0, 1);
    dir_rows[9]  = mk_row(OpDiv, longint'(SMin), -1, 1, 0, 1);
    dir_rows[10] = mk_row(OpDiv, -7, 2, 1, -3, 0);
    dir_rows[11] = mk_row(OpDiv, longint'(SMin), 1, 1, longint'(SMin), 0);
    dir_rows[12] = mk_row(OpMod, -7, 3, 1, 0, 1);
    dir_rows[13] = mk_row(OpMod, 7, 0, 1, 0, 1);
    dir_rows[14] = mk_row(OpMod, longint'(SMax), 1000);
    dir_rows[15] = mk_row(OpAnd, -1, 3, 1, 0, 1);
    dir_rows[16] = mk_row(OpOr, longint'(SMax), 0, 1, longint'(SMax), 0);
    dir_rows[17] = mk_row(OpXor, longint'(SMax), 12345);
    dir_rows[18] = mk_row(OpShift, -1, 1, 1, 0, 1);
    dir_rows[19] = mk_row(OpShift, 1, MagnitudeBits, 1, 0, 1);
    dir_rows[20] = mk_row(OpShift, 1, -MagnitudeBits, 1, 0, 1);
    dir_rows[21] = mk_row(OpShift, 1, MagnitudeBits - 1, 1, 1 << (MagnitudeBits - 1), 0);
    dir_rows[22] = mk_row(OpShift, 2, MagnitudeBits - 1, 1, 0, 1);
    dir_rows[23] = mk_row(OpShift, longint'(SMax), -(MagnitudeBits - 1), 1, 1, 0);
    dir_rows[24] = mk_row(4'd15, 1, 1, 1, 0, 1);
  end

  // Stimulus: directed table, a pause until drained, then random beats.
  initial begin
    alu_res_t typed;
    fail_count = 0; sent_count = 0; taken_count = 0;
    no_idle = 1'b0; hold_sink = 1'b0; stim_done = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      // Cross-check typed-in expectations against the predictor.
      typed = predict_alu(dir_rows[i].kind, dir_rows[i].a, dir_rows[i].b);
      if (dir_rows[i].known && (typed.val != dir_rows[i].val || typed.err != dir_rows[i].err))
      begin
        $display("%0t: row %0d expected %h/%b, predicted %h/%b", $time, i,
                 dir_rows[i].val, dir_rows[i].err, typed.val, typed.err);
        fail_count++;
      end
      send_op(dir_rows[i].kind, dir_rows[i].a, dir_rows[i].b);
    end
    s_axis_tvalid_i <= 1'b0;
    // Pause until every result is back.
    while (awaited_results.size() != 0) @(posedge clk_i);
    for (int n = 0; n < RandItems; n++) begin
      logic [3:0] kind;
      no_idle   = (n >= 400 && n < 650);
      if (n == 900) hold_sink = 1'b1;
      if (n == 1000) hold_sink = 1'b0;
      kind = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
      if (kind == OpShift && $urandom_range(0, 1))
        send_op(kind, FieldW'($urandom_range(0, 1 << $urandom_range(0, 29))),
                FieldW'(signed'($urandom_range(0, 70)) - 35));
      else
        send_op(kind, pick_operand(), pick_operand());
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, a long hold-off, and a stall-free stretch.
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      m_axis_tready_i <= no_idle || ($urandom_range(0, 99) >= 29);
    end
  end

  // Checker and watchdog.
  always @(posedge clk_i) begin
    alu_res_t want;
    bit       moved;
    if (rst_ni) begin
      moved = (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i);
      if (moved) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        taken_count <= taken_count + 1;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, m_axis_tdata_o, m_axis_tuser_o);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tdata_o != {1'b0, want.val} || m_axis_tuser_o != want.err) begin
            $display("%0t: expected value %h status %b, got %h status %b", $time,
                     want.val, want.err, m_axis_tdata_o, m_axis_tuser_o);
            fail_count++;
          end
        end
      end
      if (quiet_cycles > CyclesLimit) begin
        $display("Verification failed");
        $finish;
      end
    end else quiet_cycles <= 0;
  end

  // Drain, settle, and report.
  initial begin
    wait (stim_done);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
    $display("Covered %0d beats in, %0d results out: all opcodes, range edges, stalls.",
             sent_count, taken_count);
    if (fail_count == 0 && awaited_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
